/* hw/rtl/uoi_pkg.sv */
// ----------------------------------------------------------------------------
// uoi_pkg: shared types and constants of the odometry integrator
// Fixed-point constants, arctangent table, sequencer states and the structs
// between the sequencer and the CORDIC unit.
// ----------------------------------------------------------------------------
package uoi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;

  localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;
  localparam logic signed [31:0] RAD_TO_BAM    = 32'sd683565276;
  localparam logic [15:0]        TIME_STEP_RST = 16'd6554;

  // func codes of an input item
  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_V,
    ST_MUL_W,
    ST_MUL_H,
    ST_HEAD,
    ST_WAIT1,
    ST_MUL_X,
    ST_MUL_Y,
    ST_POS_Y,
    ST_WAIT2
  } seq_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] cos_val;
    logic [31:0] sin_val;
  } cor_rsp_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic signed [32:0] atan_ang(input logic [4:0] idx);
    logic signed [32:0] r;
    case (idx)
      5'd0:    r = 33'sd536870912;
      5'd1:    r = 33'sd316933406;
      5'd2:    r = 33'sd167458907;
      5'd3:    r = 33'sd85004756;
      5'd4:    r = 33'sd42667331;
      5'd5:    r = 33'sd21354465;
      5'd6:    r = 33'sd10679838;
      5'd7:    r = 33'sd5340245;
      5'd8:    r = 33'sd2670163;
      5'd9:    r = 33'sd1335087;
      5'd10:   r = 33'sd667544;
      5'd11:   r = 33'sd333772;
      5'd12:   r = 33'sd166886;
      5'd13:   r = 33'sd83443;
      5'd14:   r = 33'sd41722;
      5'd15:   r = 33'sd20861;
      5'd16:   r = 33'sd10430;
      5'd17:   r = 33'sd5215;
      5'd18:   r = 33'sd2608;
      5'd19:   r = 33'sd1304;
      5'd20:   r = 33'sd652;
      5'd21:   r = 33'sd326;
      5'd22:   r = 33'sd163;
      5'd23:   r = 33'sd81;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/uoi_ifs.sv */
// ----------------------------------------------------------------------------
// uoi_ifs: channel interfaces of the odometry integrator
// Command/tick input, pose output and time-step configuration channels.
// ----------------------------------------------------------------------------
interface uoi_cmd_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] linear_speed;
  logic signed [15:0] yaw_rate;

  modport source (output valid, func, linear_speed, yaw_rate, input ready);
  modport sink   (input valid, func, linear_speed, yaw_rate, output ready);
endinterface

interface uoi_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

interface uoi_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] time_step;

  modport source (output valid, time_step, input ready);
  modport sink   (input valid, time_step, output ready);
endinterface

/* hw/rtl/uoi_cordic.sv */
// ----------------------------------------------------------------------------
// uoi_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle; gives sine and cosine of a 32-bit binary
// angle in Q2.30, with half-turn folding for the left half-plane.
// ----------------------------------------------------------------------------
module uoi_cordic
  import uoi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int CW    = $clog2(NSTEP);

  logic               busy_q;
  logic [CW-1:0]      cnt_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q, x_d, y_d;
  logic signed [32:0] z_q, z_d;
  logic signed [33:0] x_sh, y_sh, cx, cy;
  logic signed [32:0] ang;
  logic [31:0]        fold_chk;
  logic [31:0]        folded;

  assign fold_chk = req_i.angle + 32'h4000_0000;
  assign folded   = fold_chk[31] ? (req_i.angle ^ 32'h8000_0000) : req_i.angle;

  // arithmetic shift gives the floor
  assign x_sh = x_q >>> cnt_q;
  assign y_sh = y_q >>> cnt_q;
  assign ang  = atan_ang(5'(cnt_q));

  always_comb begin
    if (!z_q[32]) begin
      x_d = x_q - y_sh;
      y_d = y_q + x_sh;
      z_d = z_q - ang;
    end else begin
      x_d = x_q + y_sh;
      y_d = y_q - x_sh;
      z_d = z_q + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CW'(NSTEP - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      flip_q <= fold_chk[31];
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= {folded[31], folded};
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign cx = flip_q ? -x_q : x_q;
  assign cy = flip_q ? -y_q : y_q;

  assign rsp_o.busy    = busy_q;
  assign rsp_o.cos_val = cx[31:0];
  assign rsp_o.sin_val = cy[31:0];

endmodule

/* hw/rtl/unicycle_odometry_integrator.sv */
// ----------------------------------------------------------------------------
// unicycle_odometry_integrator: dead-reckoning pose integrator
// Sequencer around one shared 33x32 multiplier and an iterative CORDIC.
// ----------------------------------------------------------------------------
// cmd_i carries input items: func = command stores linear speed and yaw rate
// and is taken with no result; func = tick advances the pose.
// pose_o carries one result item per tick: x, y (Q16.16, saturating), the
// 16-bit heading and the yaw quaternion z/w (Q1.14).
// cfg_i writes the time step (Q0.16 s); it is always ready.
// A tick is two CORDIC runs of one micro-rotation per cycle (old heading
// for the motion, new half-heading for the quaternion) and five passes
// through the shared multiplier, partly overlapped with the first run.
// cmd_i.ready is low for the whole tick; the next item is taken at the
// earliest in the cycle after the tick's result is loaded, so ticks never
// overlap.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver still stalls when the next tick finishes, the
// sequencer holds that tick until the register frees.
// Reset clears pose, stored command and output valid; time step goes to 0.1 s.
// ----------------------------------------------------------------------------
module unicycle_odometry_integrator
  import uoi_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  uoi_cmd_if.sink    cmd_i,
  uoi_pose_if.source pose_o,
  uoi_cfg_if.sink    cfg_i
);

  seq_state_e state_q, state_d;

  logic [15:0]        time_step_q;
  logic signed [15:0] speed_q, yaw_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0]        heading_q;
  logic signed [32:0] vdt_q;
  logic signed [64:0] prod_q, prod_d;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;

  logic vdt_en, pos_x_en, pos_y_en, head_en, pose_load, cmd_rdy;

  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  logic               pose_valid_q;
  logic signed [31:0] pose_x_q, pose_y_q;
  logic [15:0]        pose_head_q;
  logic signed [15:0] quat_z_q, quat_w_q;

  logic signed [64:0] rnd_pos, rnd_head;
  logic signed [31:0] pos_new;
  logic [15:0]        delta;

  logic cmd_acc;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [22:0] d);
    logic signed [33:0] s;
    logic signed [31:0] r;
    s = 34'(p) + 34'(d);
    if (s > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] quat_val(input logic signed [31:0] q);
    logic signed [32:0] t;
    logic signed [16:0] r;
    logic signed [15:0] o;
    t = 33'(q) + 33'sd32768;
    r = t[32:16];
    if (r > 17'sd16384) begin
      o = 16'sd16384;
    end else if (r < -17'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  uoi_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cor_req),
    .rsp_o (cor_rsp)
  );

  assign cmd_acc = cmd_i.valid && cmd_rdy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_acc && cmd_i.func == FUNC_TICK) begin
          state_d = ST_MUL_V;
        end
      end
      ST_MUL_V: state_d = ST_MUL_W;
      ST_MUL_W: state_d = ST_MUL_H;
      ST_MUL_H: state_d = ST_HEAD;
      ST_HEAD:  state_d = ST_WAIT1;
      ST_WAIT1: begin
        if (!cor_rsp.busy) begin
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: state_d = ST_MUL_Y;
      ST_MUL_Y: state_d = ST_POS_Y;
      ST_POS_Y: state_d = ST_WAIT2;
      ST_WAIT2: begin
        if (!cor_rsp.busy && (!pose_valid_q || pose_o.ready)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_rdy       = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    cor_req.start = 1'b0;
    cor_req.angle = '0;
    vdt_en        = 1'b0;
    pos_x_en      = 1'b0;
    pos_y_en      = 1'b0;
    head_en       = 1'b0;
    pose_load     = 1'b0;
    case (state_q)
      ST_IDLE: cmd_rdy = 1'b1;
      ST_MUL_V: begin
        mul_a         = 33'(speed_q);
        mul_b         = {16'b0, time_step_q};
        cor_req.start = 1'b1;
        cor_req.angle = {heading_q, 16'b0};
      end
      ST_MUL_W: begin
        mul_a  = 33'(yaw_q);
        mul_b  = {16'b0, time_step_q};
        vdt_en = 1'b1;
      end
      ST_MUL_H: begin
        mul_a = prod_q[32:0];
        mul_b = RAD_TO_BAM;
      end
      ST_HEAD:  head_en = 1'b1;
      ST_WAIT1: ;
      ST_MUL_X: begin
        mul_a = vdt_q;
        mul_b = $signed(cor_rsp.cos_val);
      end
      ST_MUL_Y: begin
        pos_x_en = 1'b1;
        mul_a    = vdt_q;
        mul_b    = $signed(cor_rsp.sin_val);
      end
      ST_POS_Y: begin
        pos_y_en      = 1'b1;
        cor_req.start = 1'b1;
        cor_req.angle = {1'b0, heading_q, 15'b0};
      end
      ST_WAIT2: pose_load = !cor_rsp.busy && (!pose_valid_q || pose_o.ready);
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // rounding of the motion and heading products
  assign rnd_pos  = prod_q + (65'sd1 <<< 41);
  assign rnd_head = prod_q + (65'sd1 <<< 43);
  assign delta    = rnd_head[59:44];
  assign pos_new  = sat_add(pos_x_en ? pos_x_q : pos_y_q, rnd_pos[64:42]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_step_q  <= TIME_STEP_RST;
      speed_q      <= '0;
      yaw_q        <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      heading_q    <= '0;
      pose_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        time_step_q <= cfg_i.time_step;
      end
      if (cmd_acc && cmd_i.func == FUNC_CMD) begin
        speed_q <= cmd_i.linear_speed;
        yaw_q   <= cmd_i.yaw_rate;
      end
      if (pos_x_en) begin
        pos_x_q <= pos_new;
      end
      if (pos_y_en) begin
        pos_y_q <= pos_new;
      end
      if (head_en) begin
        heading_q <= heading_q + delta;
      end
      if (pose_load) begin
        pose_valid_q <= 1'b1;
      end else if (pose_o.ready) begin
        pose_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (vdt_en) begin
      vdt_q <= prod_q[32:0];
    end
    if (pose_load) begin
      pose_x_q    <= pos_x_q;
      pose_y_q    <= pos_y_q;
      pose_head_q <= heading_q;
      quat_z_q    <= quat_val($signed(cor_rsp.sin_val));
      quat_w_q    <= quat_val($signed(cor_rsp.cos_val));
    end
  end

  assign cmd_i.ready    = cmd_rdy;
  assign cfg_i.ready    = 1'b1;
  assign pose_o.valid   = pose_valid_q;
  assign pose_o.pos_x   = pose_x_q;
  assign pose_o.pos_y   = pose_y_q;
  assign pose_o.heading = pose_head_q;
  assign pose_o.quat_z  = quat_z_q;
  assign pose_o.quat_w  = quat_w_q;

endmodule

/* hw/rtl/uoi_checker.sv */
// ----------------------------------------------------------------------------
// uoi_checker: port-level checks of the odometry integrator
// Watches the command and pose channels; bound to the top level.
// ----------------------------------------------------------------------------
module uoi_checker
  import uoi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cmd_valid_i,
  input logic               cmd_ready_i,
  input logic               cmd_func_i,
  input logic               pose_valid_i,
  input logic               pose_ready_i,
  input logic signed [31:0] pose_x_i,
  input logic signed [15:0] quat_z_i,
  input logic signed [15:0] quat_w_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_valid_i && !pose_ready_i |=> pose_valid_i && $stable(pose_x_i))
    else $error("pose item dropped or changed under stall");

  // an accepted tick drops the input ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && cmd_func_i == FUNC_TICK |=> !cmd_ready_i)
    else $error("input ready during a tick");

  // a command item never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && cmd_func_i == FUNC_CMD && !pose_valid_i
      |=> !pose_valid_i)
    else $error("result after a command item");

  // a new result only appears at the end of a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pose_valid_i) |-> $past(!cmd_ready_i))
    else $error("result without a running tick");

  // quaternion stays on the unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_valid_i |-> quat_z_i <= 16'sd16384 && quat_z_i >= -16'sd16384
                  && quat_w_i <= 16'sd16384 && quat_w_i >= -16'sd16384)
    else $error("quaternion out of range");

endmodule

bind unicycle_odometry_integrator uoi_checker u_uoi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .cmd_func_i  (cmd_i.func),
  .pose_valid_i(pose_o.valid),
  .pose_ready_i(pose_o.ready),
  .pose_x_i    (pose_o.pos_x),
  .quat_z_i    (pose_o.quat_z),
  .quat_w_i    (pose_o.quat_w)
);
